FILE: hw/rtl/lbft_pkg.sv
// shared constants and codes for the linked block file table
package lbft_pkg;

	localparam int NUM_ENTRIES_DEF = 16;
	localparam int NUM_BLOCKS_DEF  = 256;

	localparam int CMD_W    = 3;
	localparam int NAME_W   = 64;
	localparam int ENTIDX_W = 4;
	localparam int BLKIDX_W = 8;
	localparam int VAL_W    = 9;
	localparam int STAT_W   = 2;

	localparam logic [VAL_W-1:0] NOT_FOUND = 9'd255;

	typedef enum logic [CMD_W-1:0] {
		CMD_FORMAT    = 3'd0,
		CMD_ALLOC     = 3'd1,
		CMD_FREE      = 3'd2,
		CMD_FIND      = 3'd3,
		CMD_CREATE    = 3'd4,
		CMD_SET_LINK  = 3'd5,
		CMD_SET_START = 3'd6,
		CMD_NOP       = 3'd7
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DIR_FULL  = 2'd2,
		ST_NO_BLOCK  = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/lbft_ram.sv
// simple dual port ram, one write port and one registered read port
module lbft_ram #(
	parameter int W = 9,
	parameter int D = 256,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/linked_block_file_table.sv
// Linked block file table: link table, free list head and named directory.
// Format rebuilds the free list by a sweep (one link written per cycle); allocate takes the free
// list head, or reports no block on an empty free list; free walks the file's chain block by block,
// find and create scan the directory; set link, set start and unused go straight to the response.
// One request at a time; in_ready rises as its result is registered in the output register.
// After reset a sweep links every block before the first request is taken.
module linked_block_file_table #(
	parameter int NUM_ENTRIES = lbft_pkg::NUM_ENTRIES_DEF,
	parameter int NUM_BLOCKS  = lbft_pkg::NUM_BLOCKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lbft_pkg::CMD_W-1:0]    cmd,
	input  logic [lbft_pkg::NAME_W-1:0]   file_name,
	input  logic [lbft_pkg::ENTIDX_W-1:0] entry_index,
	input  logic [lbft_pkg::BLKIDX_W-1:0] block_index,
	input  logic [lbft_pkg::VAL_W-1:0]    link_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lbft_pkg::STAT_W-1:0]   status,
	output logic [lbft_pkg::VAL_W-1:0]    result_value
);
	import lbft_pkg::*;

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int LW = ($clog2(NUM_BLOCKS + 1) > VAL_W) ? $clog2(NUM_BLOCKS + 1) : VAL_W;
	localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam logic [LW-1:0] END_MARK = LW'(NUM_BLOCKS);
	localparam logic [BW-1:0] LAST_BLK = BW'(NUM_BLOCKS - 1);
	localparam logic [CW-1:0] LAST_ENT = CW'(NUM_ENTRIES - 1);
	localparam logic [CW-1:0] NUM_ENT  = CW'(NUM_ENTRIES);

	typedef enum logic [8:0] {
		S_SWEEP    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_EXEC     = 9'b000000100,
		S_ALLOC_WR = 9'b000001000,
		S_FREE_CHK = 9'b000010000,
		S_WALK     = 9'b000100000,
		S_FIND     = 9'b001000000,
		S_CREATE   = 9'b010000000,
		S_RESP     = 9'b100000000
	} state_t;

	state_t state_q;

	// latched request
	cmd_t                cmd_q;
	logic [NAME_W-1:0]   name_q;
	logic [ENTIDX_W-1:0] ent_q;
	logic [BLKIDX_W-1:0] blk_q;
	logic [VAL_W-1:0]    val_q;

	// control state
	logic [LW-1:0]          free_head_q;
	logic [NUM_ENTRIES-1:0] used_q;
	logic [NUM_ENTRIES-1:0] start_vld_q;
	logic [BW-1:0]          bcnt_q;
	logic                   fmt_resp_q;
	logic [LW-1:0]          cur_q;
	logic [LW-1:0]          first_q;
	logic [BW-1:0]          steps_q;
	logic [CW-1:0]          scnt_q;
	logic                   fvld_s1;
	logic [EW-1:0]          fidx_s1;
	status_t                res_stat_q;
	logic [VAL_W-1:0]       res_val_q;

	// output register
	logic              out_vld_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [VAL_W-1:0]  out_val_q;

	// memory ports
	logic          link_we;
	logic [BW-1:0] link_waddr;
	logic [LW-1:0] link_wdata;
	logic [BW-1:0] link_raddr;
	logic [LW-1:0] link_rdata;
	logic          name_we;
	logic [EW-1:0] name_addr_w;
	logic [EW-1:0] name_raddr;
	logic [NAME_W-1:0] name_rdata;
	logic          start_we;
	logic [LW-1:0] start_rdata;

	// decoded helpers
	logic          ent_ok;
	logic          blk_ok;
	logic [EW-1:0] ent_idx;
	logic [EW-1:0] sidx;
	logic [LW-1:0] first_val;
	logic          nxt_end;
	logic          find_hit;

	assign ent_ok    = 32'(ent_q) < NUM_ENTRIES;
	assign blk_ok    = 32'(blk_q) < NUM_BLOCKS;
	assign ent_idx   = EW'(ent_q);
	assign sidx      = scnt_q[EW-1:0];
	assign first_val = start_vld_q[ent_idx] ? start_rdata : END_MARK;
	assign nxt_end   = link_rdata >= END_MARK;
	assign find_hit  = fvld_s1 && used_q[fidx_s1] && (name_rdata == name_q);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_vld_q;
	assign status       = out_stat_q;
	assign result_value = out_val_q;

	lbft_ram #(.W(LW), .D(NUM_BLOCKS), .AW(BW)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	lbft_ram #(.W(NAME_W), .D(NUM_ENTRIES), .AW(EW)) u_name (
		.clk   (clk),
		.we    (name_we),
		.waddr (name_addr_w),
		.wdata (name_q),
		.raddr (name_raddr),
		.rdata (name_rdata)
	);

	lbft_ram #(.W(LW), .D(NUM_ENTRIES), .AW(EW)) u_start (
		.clk   (clk),
		.we    (start_we),
		.waddr (ent_idx),
		.wdata (LW'(val_q)),
		.raddr (ent_idx),
		.rdata (start_rdata)
	);

	// memory port control
	always_comb begin
		link_we     = 1'b0;
		link_waddr  = bcnt_q;
		link_wdata  = LW'(bcnt_q) + LW'(1);
		link_raddr  = free_head_q[BW-1:0];
		name_we     = 1'b0;
		name_addr_w = sidx;
		name_raddr  = sidx;
		start_we    = 1'b0;
		case (state_q)
			S_SWEEP: begin
				link_we = 1'b1;
			end
			S_EXEC: begin
				if (cmd_q == CMD_SET_LINK && blk_ok) begin
					link_we    = 1'b1;
					link_waddr = BW'(blk_q);
					link_wdata = LW'(val_q);
				end
				if (cmd_q == CMD_SET_START && ent_ok) begin
					start_we = 1'b1;
				end
			end
			S_ALLOC_WR: begin
				link_we    = 1'b1;
				link_waddr = free_head_q[BW-1:0];
				link_wdata = END_MARK;
			end
			S_FREE_CHK: begin
				link_raddr = first_val[BW-1:0];
			end
			S_WALK: begin
				link_raddr = link_rdata[BW-1:0];
				if (nxt_end) begin
					link_we    = 1'b1;
					link_waddr = cur_q[BW-1:0];
					link_wdata = free_head_q;
				end
			end
			S_CREATE: begin
				name_we = !used_q[sidx];
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			free_head_q <= '0;
			used_q      <= '0;
			start_vld_q <= '0;
			bcnt_q      <= '0;
			fmt_resp_q  <= 1'b0;
			scnt_q      <= '0;
			fvld_s1     <= 1'b0;
			res_stat_q  <= ST_OK;
			res_val_q   <= '0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					bcnt_q <= bcnt_q + BW'(1);
					if (bcnt_q == LAST_BLK) begin
						state_q <= fmt_resp_q ? S_RESP : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_stat_q <= ST_OK;
					res_val_q  <= '0;
					state_q    <= S_RESP;
					scnt_q     <= '0;
					fvld_s1    <= 1'b0;
					case (cmd_q)
						CMD_FORMAT: begin
							free_head_q <= '0;
							used_q      <= '0;
							start_vld_q <= '0;
							bcnt_q      <= '0;
							fmt_resp_q  <= 1'b1;
							state_q     <= S_SWEEP;
						end
						CMD_ALLOC: begin
							if (free_head_q < END_MARK) begin
								state_q <= S_ALLOC_WR;
							end else begin
								res_stat_q <= ST_NO_BLOCK;
								res_val_q  <= VAL_W'(END_MARK);
							end
						end
						CMD_FREE: begin
							if (ent_ok) begin
								state_q <= S_FREE_CHK;
							end
						end
						CMD_FIND: begin
							state_q <= S_FIND;
						end
						CMD_CREATE: begin
							state_q <= S_CREATE;
						end
						CMD_SET_START: begin
							if (ent_ok) begin
								start_vld_q[ent_idx] <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_ALLOC_WR: begin
					free_head_q <= link_rdata;
					res_val_q   <= VAL_W'(free_head_q);
					state_q     <= S_RESP;
				end
				S_FREE_CHK: begin
					first_q <= first_val;
					cur_q   <= first_val;
					steps_q <= '0;
					if (first_val < END_MARK) begin
						state_q <= S_WALK;
					end else begin
						used_q[ent_idx]      <= 1'b0;
						start_vld_q[ent_idx] <= 1'b0;
						state_q              <= S_RESP;
					end
				end
				S_WALK: begin
					if (nxt_end || steps_q == LAST_BLK) begin
						if (nxt_end) begin
							free_head_q <= first_q;
						end
						used_q[ent_idx]      <= 1'b0;
						start_vld_q[ent_idx] <= 1'b0;
						state_q              <= S_RESP;
					end else begin
						cur_q   <= link_rdata;
						steps_q <= steps_q + BW'(1);
					end
				end
				S_FIND: begin
					// read issue runs one entry ahead of the compare
					fvld_s1 <= scnt_q < NUM_ENT;
					fidx_s1 <= sidx;
					if (scnt_q < NUM_ENT) begin
						scnt_q <= scnt_q + CW'(1);
					end
					if (find_hit) begin
						res_val_q <= VAL_W'(fidx_s1);
						state_q   <= S_RESP;
					end else if (fvld_s1 && CW'(fidx_s1) == LAST_ENT) begin
						res_stat_q <= ST_NOT_FOUND;
						res_val_q  <= NOT_FOUND;
						state_q    <= S_RESP;
					end
				end
				S_CREATE: begin
					if (!used_q[sidx]) begin
						used_q[sidx]      <= 1'b1;
						start_vld_q[sidx] <= 1'b0;
						res_val_q         <= VAL_W'(sidx);
						state_q           <= S_RESP;
					end else if (scnt_q == LAST_ENT) begin
						res_stat_q <= ST_DIR_FULL;
						res_val_q  <= NOT_FOUND;
						state_q    <= S_RESP;
					end else begin
						scnt_q <= scnt_q + CW'(1);
					end
				end
				S_RESP: begin
					if (!out_vld_q || out_ready) begin
						fmt_resp_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd_t'(cmd);
			name_q <= file_name;
			ent_q  <= entry_index;
			blk_q  <= block_index;
			val_q  <= link_value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_RESP && (!out_vld_q || out_ready)) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_vld_q || out_ready)) begin
			out_stat_q <= res_stat_q;
			out_val_q  <= res_val_q;
		end
	end
endmodule
